// ===== src/tcpop_pkg.sv =====
// Shared types, codes and helper functions for the TCP option parser.
// Used by tcpop_step and tcp_option_parser; no dependencies.
package tcpop_pkg;

  localparam logic [5:0] MAX_OPTION_BYTES = 6'd40;
  localparam logic [5:0] LEN_TOO_LONG     = 6'd63;
  localparam logic [5:0] OFFSET_MAX       = 6'd63;

  localparam logic [7:0] KIND_EOL  = 8'd0;
  localparam logic [7:0] KIND_NOP  = 8'd1;
  localparam logic [7:0] KIND_MSS  = 8'd2;
  localparam logic [7:0] KIND_WS   = 8'd3;
  localparam logic [7:0] KIND_SACKP = 8'd4;
  localparam logic [7:0] KIND_SACK = 8'd5;
  localparam logic [7:0] KIND_TS   = 8'd8;

  localparam logic [3:0] T_NOP   = 4'd0;
  localparam logic [3:0] T_MSS   = 4'd1;
  localparam logic [3:0] T_SACKP = 4'd2;
  localparam logic [3:0] T_SACK  = 4'd3;
  localparam logic [3:0] T_WS    = 4'd4;
  localparam logic [3:0] T_TS    = 4'd5;
  localparam logic [3:0] T_EOL   = 4'd6;
  localparam logic [3:0] T_UNK   = 4'd7;
  localparam logic [3:0] T_END   = 4'd8;

  typedef enum logic [2:0] {
    PH_KIND = 3'b001,
    PH_LEN  = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  kind;
    logic [5:0]  decl_len;
    logic [5:0]  offset;
    logic [31:0] accum_first;
    logic [31:0] accum_second;
    logic        walk_done;
  } walk_state_t;

  localparam walk_state_t WALK_CLEAR = '{
    phase:        PH_KIND,
    kind:         8'd0,
    decl_len:     6'd0,
    offset:       6'd0,
    accum_first:  32'd0,
    accum_second: 32'd0,
    walk_done:    1'b0
  };

  typedef struct packed {
    logic        malformed;
    logic        value_valid;
    logic [31:0] value_second;
    logic [31:0] value_first;
    logic [5:0]  opt_length;
    logic [7:0]  opt_kind;
    logic [3:0]  opt_type;
    logic        last_record;
  } opt_rec_t;

  function automatic logic [3:0] type_of(input logic [7:0] kind);
    logic [3:0] t;
    case (kind)
      KIND_EOL:   t = T_EOL;
      KIND_NOP:   t = T_NOP;
      KIND_MSS:   t = T_MSS;
      KIND_WS:    t = T_WS;
      KIND_SACKP: t = T_SACKP;
      KIND_SACK:  t = T_SACK;
      KIND_TS:    t = T_TS;
      default:    t = T_UNK;
    endcase
    return t;
  endfunction

  function automatic logic [5:0] first_bytes(input logic [7:0] kind);
    logic [5:0] n;
    case (kind)
      KIND_MSS: n = 6'd2;
      KIND_WS:  n = 6'd1;
      KIND_TS:  n = 6'd4;
      default:  n = 6'd0;
    endcase
    return n;
  endfunction

  function automatic logic [5:0] need_bytes(input logic [7:0] kind);
    logic [5:0] n;
    case (kind)
      KIND_MSS: n = 6'd4;
      KIND_WS:  n = 6'd3;
      KIND_TS:  n = 6'd10;
      default:  n = 6'd0;
    endcase
    return n;
  endfunction

  function automatic opt_rec_t option_record(input walk_state_t st, input logic bad,
                                             input logic last);
    opt_rec_t   r;
    logic [5:0] need;
    logic       ok;
    need = need_bytes(st.kind);
    ok = (need != 6'd0) && (st.decl_len >= need) && (st.offset >= need);
    r.opt_type     = type_of(st.kind);
    r.opt_kind     = st.kind;
    r.opt_length   = st.decl_len;
    r.value_first  = ok ? st.accum_first : 32'd0;
    r.value_second = (ok && st.kind == KIND_TS) ? st.accum_second : 32'd0;
    r.value_valid  = ok;
    r.malformed    = bad;
    r.last_record  = last;
    return r;
  endfunction

endpackage

// ===== src/tcp_option_parser.sv =====
// TCP header option parser: top level with input, walk state and result registers.
// Depends on tcpop_pkg and tcpop_step.
//
// Usage: feed the option area one byte per beat on in_tdata, in header order,
// with in_tlast high on the area's final byte. Each beat yields zero or one
// record on the out_ channel: out_tuser gives the option type, out_tdata the
// kind, length, decoded values and status flags, out_tlast marks the record
// made by the area's last byte. Every area ends in exactly one record with
// out_tlast high.
// Path: the input register captures each byte, then the walk step loads its
// record into the result register; a low out_tready can keep the byte waiting.
// Throughput: one byte per cycle with out_tready high; the walk step is a single
// combinational pass from the input register into the state and result registers.
// Reset (rst_n low, synchronous) empties both registers and returns the walk
// to expect a kind byte. When the receiver holds out_tready low, the result
// register holds its record, the byte in the input register waits, and
// in_tready drops once that register is also occupied.
module tcp_option_parser import tcpop_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] opt_byte
  input  logic        in_tlast,   // area_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [7:0] opt_kind, [13:8] opt_length,
                                  // [45:14] value_first, [77:46] value_second,
                                  // [78] value_valid, [79] malformed
  output logic [3:0]  out_tuser,  // [3:0] opt_type
  output logic        out_tlast   // last_record
);

  logic        in_valid_r;
  logic [7:0]  byte_r;
  logic        last_r;
  walk_state_t st_r;
  walk_state_t st_nxt;
  logic        emit;
  opt_rec_t    rec;
  opt_rec_t    out_r;
  logic        out_valid_r;
  logic        out_free;
  logic        step_go;

  assign out_free  = !out_valid_r || out_tready;
  assign step_go   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || step_go;

  tcpop_step u_step (
    .st        (st_r),
    .opt_byte  (byte_r),
    .area_last (last_r),
    .st_nxt    (st_nxt),
    .emit      (emit),
    .rec       (rec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= WALK_CLEAR;
    end else begin
      if (in_tvalid && in_tready) begin
        in_valid_r <= 1'b1;
      end else if (step_go) begin
        in_valid_r <= 1'b0;
      end
      if (step_go) begin
        st_r <= st_nxt;
      end
      if (step_go && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
    if (step_go && emit) begin
      out_r <= rec;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.opt_type;
  assign out_tlast  = out_r.last_record;
  assign out_tdata  = {out_r.malformed, out_r.value_valid, out_r.value_second,
                       out_r.value_first, out_r.opt_length, out_r.opt_kind};

`ifndef SYNTHESIS
  a_end_only_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == T_END |-> out_tlast && out_tdata == 80'd0)
    else $error("end-only record carries data or lacks last");

  a_second_ts_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != T_TS |-> out_tdata[77:46] == 32'd0)
    else $error("value_second set on a non-timestamp record");

  a_done_in_kind: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.walk_done |-> st_r.phase == PH_KIND)
    else $error("finished walk left in a non-kind phase");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !step_go |=> in_valid_r && $stable(byte_r) && $stable(last_r))
    else $error("waiting byte lost or overwritten");
`endif

endmodule

// ===== src/tcpop_step.sv =====
// Next-state and record logic for one option-area byte.
// Depends on tcpop_pkg.
module tcpop_step import tcpop_pkg::*; (
  input  walk_state_t st,
  input  logic [7:0]  opt_byte,
  input  logic        area_last,
  output walk_state_t st_nxt,
  output logic        emit,
  output opt_rec_t    rec
);

  walk_state_t body;
  logic [5:0]  pos;
  logic [5:0]  fb;

  always_comb begin
    pos = st.offset;
    fb  = first_bytes(st.kind);
    body = st;
    if (pos >= 6'd2 && pos < 6'd2 + fb) begin
      body.accum_first = {st.accum_first[23:0], opt_byte};
    end
    if (st.kind == KIND_TS && pos >= 6'd6 && pos < 6'd10) begin
      body.accum_second = {st.accum_second[23:0], opt_byte};
    end
    if (pos < OFFSET_MAX) begin
      body.offset = pos + 6'd1;
    end
  end

  always_comb begin
    walk_state_t s;
    s      = st;
    st_nxt = st;
    emit   = 1'b0;
    rec    = '0;
    if (st.walk_done) begin
      if (area_last) begin
        emit = 1'b1;
        rec.opt_type    = T_END;
        rec.last_record = 1'b1;
        st_nxt = WALK_CLEAR;
      end
    end else begin
      unique case (st.phase)
        PH_KIND: begin
          s.kind         = opt_byte;
          s.decl_len     = 6'd0;
          s.offset       = 6'd1;
          s.accum_first  = 32'd0;
          s.accum_second = 32'd0;
          st_nxt = s;
          if (opt_byte == KIND_NOP) begin
            emit = 1'b1;
            rec.opt_type    = T_NOP;
            rec.opt_kind    = KIND_NOP;
            rec.opt_length  = 6'd1;
            rec.last_record = area_last;
            if (area_last) st_nxt = WALK_CLEAR;
          end else if (opt_byte == KIND_EOL) begin
            emit = 1'b1;
            rec.opt_type    = T_EOL;
            rec.opt_kind    = KIND_EOL;
            rec.opt_length  = 6'd1;
            rec.last_record = area_last;
            if (area_last) begin
              st_nxt = WALK_CLEAR;
            end else begin
              st_nxt.walk_done = 1'b1;
              st_nxt.phase     = PH_KIND;
            end
          end else if (area_last) begin
            emit   = 1'b1;
            rec    = option_record(s, 1'b1, 1'b1);
            st_nxt = WALK_CLEAR;
          end else begin
            st_nxt.phase = PH_LEN;
          end
        end
        PH_LEN: begin
          s.offset = 6'd2;
          if (opt_byte < 8'd2) begin
            s.decl_len = opt_byte[5:0];
            emit = 1'b1;
            rec  = option_record(s, 1'b1, area_last);
            st_nxt = s;
            if (area_last) begin
              st_nxt = WALK_CLEAR;
            end else begin
              st_nxt.walk_done = 1'b1;
              st_nxt.phase     = PH_KIND;
            end
          end else if (opt_byte > {2'b00, MAX_OPTION_BYTES}) begin
            s.decl_len = LEN_TOO_LONG;
            emit = 1'b1;
            rec.opt_type    = type_of(st.kind);
            rec.opt_kind    = st.kind;
            rec.opt_length  = LEN_TOO_LONG;
            rec.malformed   = 1'b1;
            rec.last_record = area_last;
            st_nxt = s;
            if (area_last) begin
              st_nxt = WALK_CLEAR;
            end else begin
              st_nxt.walk_done = 1'b1;
              st_nxt.phase     = PH_KIND;
            end
          end else begin
            s.decl_len = opt_byte[5:0];
            st_nxt = s;
            if (opt_byte == 8'd2) begin
              emit = 1'b1;
              rec  = option_record(s, 1'b0, area_last);
              if (area_last) st_nxt = WALK_CLEAR;
              else st_nxt.phase = PH_KIND;
            end else if (area_last) begin
              emit   = 1'b1;
              rec    = option_record(s, 1'b1, 1'b1);
              st_nxt = WALK_CLEAR;
            end else begin
              st_nxt.phase = PH_BODY;
            end
          end
        end
        default: begin
          st_nxt = body;
          if (body.offset >= body.decl_len) begin
            emit = 1'b1;
            rec  = option_record(body, 1'b0, area_last);
            if (area_last) st_nxt = WALK_CLEAR;
            else st_nxt.phase = PH_KIND;
          end else if (area_last) begin
            emit   = 1'b1;
            rec    = option_record(body, 1'b1, 1'b1);
            st_nxt = WALK_CLEAR;
          end
        end
      endcase
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for tcp_option_parser: drives option-area bytes,
// predicts the option records, and checks every record on the out_ channel.
// Depends on tcpop_pkg and the parser RTL only.
module tb_top;
  import tcpop_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int STALL_CYCLES    = 300;
  localparam int DRAIN_CYCLES    = 8;

  class option_record_board;
    opt_rec_t    expected_records[$];
    phase_t      ph;
    logic [7:0]  kind;
    logic [5:0]  decl;
    logic [5:0]  offs;
    logic [31:0] acc1;
    logic [31:0] acc2;
    bit          done;
    int          errors;
    int          checked;
    int          walked_bytes;

    function new();
      clear_walk();
      errors = 0;
      checked = 0;
      walked_bytes = 0;
    endfunction

    function void clear_walk();
      ph   = PH_KIND;
      kind = '0;
      decl = '0;
      offs = '0;
      acc1 = '0;
      acc2 = '0;
      done = 1'b0;
    endfunction

    function logic [3:0] kind_type(logic [7:0] k);
      if (k == KIND_EOL) return T_EOL;
      if (k == KIND_NOP) return T_NOP;
      if (k == KIND_MSS) return T_MSS;
      if (k == KIND_WS) return T_WS;
      if (k == KIND_SACKP) return T_SACKP;
      if (k == KIND_SACK) return T_SACK;
      if (k == KIND_TS) return T_TS;
      return T_UNK;
    endfunction

    function int value_span(logic [7:0] k);
      return (k == KIND_MSS) ? 2 : (k == KIND_WS) ? 1 : (k == KIND_TS) ? 4 : 0;
    endfunction

    function int value_need(logic [7:0] k);
      return (k == KIND_MSS) ? 4 : (k == KIND_WS) ? 3 : (k == KIND_TS) ? 10 : 0;
    endfunction

    function opt_rec_t plain_record(logic [3:0] t, logic [7:0] k, logic [5:0] len,
                                    logic bad, logic last);
      opt_rec_t r;
      r = '0;
      r.opt_type    = t;
      r.opt_kind    = k;
      r.opt_length  = len;
      r.malformed   = bad;
      r.last_record = last;
      return r;
    endfunction

    function opt_rec_t current_record(logic bad, logic last);
      opt_rec_t r;
      int       need;
      bit       ok;
      need = value_need(kind);
      ok = need != 0 && int'(decl) >= need && int'(offs) >= need;
      r = plain_record(kind_type(kind), kind, decl, bad, last);
      r.value_valid  = ok;
      r.value_first  = ok ? acc1 : 32'd0;
      r.value_second = (ok && kind == KIND_TS) ? acc2 : 32'd0;
      return r;
    endfunction

    function void end_walk(logic last);
      if (last) begin
        clear_walk();
      end else begin
        done = 1'b1;
        ph = PH_KIND;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      int p;
      walked_bytes++;
      if (done) begin
        if (last) begin
          expected_records.push_back(plain_record(T_END, 8'd0, 6'd0, 1'b0, 1'b1));
          clear_walk();
        end
        return;
      end
      case (ph)
        PH_KIND: begin
          kind = b;
          decl = '0;
          offs = 6'd1;
          acc1 = '0;
          acc2 = '0;
          if (b == KIND_NOP) begin
            expected_records.push_back(plain_record(T_NOP, b, 6'd1, 1'b0, last));
            if (last) clear_walk();
          end else if (b == KIND_EOL) begin
            expected_records.push_back(plain_record(T_EOL, b, 6'd1, 1'b0, last));
            end_walk(last);
          end else if (last) begin
            expected_records.push_back(current_record(1'b1, 1'b1));
            clear_walk();
          end else begin
            ph = PH_LEN;
          end
        end
        PH_LEN: begin
          offs = 6'd2;
          if (b < 8'd2) begin
            decl = b[5:0];
            expected_records.push_back(current_record(1'b1, last));
            end_walk(last);
          end else if (b > 8'(MAX_OPTION_BYTES)) begin
            decl = LEN_TOO_LONG;
            expected_records.push_back(
              plain_record(kind_type(kind), kind, LEN_TOO_LONG, 1'b1, last));
            end_walk(last);
          end else begin
            decl = b[5:0];
            if (b == 8'd2) begin
              expected_records.push_back(current_record(1'b0, last));
              if (last) clear_walk();
              else ph = PH_KIND;
            end else if (last) begin
              expected_records.push_back(current_record(1'b1, 1'b1));
              clear_walk();
            end else begin
              ph = PH_BODY;
            end
          end
        end
        default: begin
          p = offs;
          if (p >= 2 && p < 2 + value_span(kind)) acc1 = {acc1[23:0], b};
          if (kind == KIND_TS && p >= 6 && p < 10) acc2 = {acc2[23:0], b};
          if (offs < OFFSET_MAX) offs = offs + 6'd1;
          if (offs >= decl) begin
            expected_records.push_back(current_record(1'b0, last));
            if (last) clear_walk();
            else ph = PH_KIND;
          end else if (last) begin
            expected_records.push_back(current_record(1'b1, 1'b1));
            clear_walk();
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $realtime, name,
                 exp_v, act_v);
      end
    endfunction

    function void check_record(opt_rec_t got);
      opt_rec_t exp_r;
      if (expected_records.size() == 0) begin
        errors++;
        $display("%0t: unexpected record: expected none, actual %h", $realtime, got);
        return;
      end
      exp_r = expected_records.pop_front();
      checked++;
      compare_field("opt_type", 32'(exp_r.opt_type), 32'(got.opt_type));
      compare_field("opt_kind", 32'(exp_r.opt_kind), 32'(got.opt_kind));
      compare_field("opt_length", 32'(exp_r.opt_length), 32'(got.opt_length));
      compare_field("value_first", exp_r.value_first, got.value_first);
      compare_field("value_second", exp_r.value_second, got.value_second);
      compare_field("value_valid", 32'(exp_r.value_valid), 32'(got.value_valid));
      compare_field("malformed", 32'(exp_r.malformed), 32'(got.malformed));
      compare_field("last_record", 32'(exp_r.last_record), 32'(got.last_record));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;

  option_record_board sb;
  int  src_idle_pct;
  int  sink_idle_pct;
  bit  stall_request;
  int  quiet_cycles;
  int  areas_sent;

  tcp_option_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    opt_rec_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        got.opt_kind     = out_tdata[7:0];
        got.opt_length   = out_tdata[13:8];
        got.value_first  = out_tdata[45:14];
        got.value_second = out_tdata[77:46];
        got.value_valid  = out_tdata[78];
        got.malformed    = out_tdata[79];
        got.opt_type     = out_tuser;
        got.last_record  = out_tlast;
        sb.check_record(got);
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("%0t: no beat accepted for %0d cycles", $realtime, quiet_cycles);
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        out_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end else begin
        out_tready <= (rst_n && $urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic send_beat(logic [7:0] b, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_area(logic [7:0] area[$]);
    foreach (area[i]) send_beat(area[i], i == area.size() - 1);
    areas_sent++;
  endtask

  function automatic void push_random(ref logic [7:0] area[$], input int n);
    repeat (n) area.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void build_area(ref logic [7:0] area[$]);
    int         target;
    int         sel;
    int         len;
    logic [7:0] k;
    area.delete();
    target = ($urandom_range(9) == 0) ? $urandom_range(60, 1) : $urandom_range(40, 1);
    while (area.size() < target) begin
      sel = $urandom_range(99);
      if (sel < 10) begin
        area.push_back(KIND_NOP);
      end else if (sel < 13) begin
        area.push_back(KIND_EOL);
      end else if (sel < 28) begin
        area.push_back(KIND_MSS);
        area.push_back(8'd4);
        push_random(area, 2);
      end else if (sel < 40) begin
        area.push_back(KIND_WS);
        area.push_back(8'd3);
        push_random(area, 1);
      end else if (sel < 48) begin
        area.push_back(KIND_SACKP);
        area.push_back(8'd2);
      end else if (sel < 58) begin
        len = 2 + 8 * $urandom_range(4, 1);
        area.push_back(KIND_SACK);
        area.push_back(8'(len));
        push_random(area, len - 2);
      end else if (sel < 75) begin
        area.push_back(KIND_TS);
        area.push_back(8'd10);
        push_random(area, 8);
      end else if (sel < 90) begin
        case ($urandom_range(5))
          0: k = KIND_MSS;
          1: k = KIND_WS;
          2: k = KIND_TS;
          3: k = KIND_SACKP;
          4: k = KIND_SACK;
          default: k = 8'($urandom_range(255));
        endcase
        len = ($urandom_range(4) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 2);
        area.push_back(k);
        area.push_back(8'(len));
        push_random(area, len - 2);
      end else if (sel < 95) begin
        area.push_back(8'($urandom_range(255)));
        if ($urandom_range(1) == 0) area.push_back(8'($urandom_range(1)));
        else area.push_back(8'($urandom_range(255, 41)));
      end else begin
        push_random(area, 1);
      end
    end
    if ($urandom_range(9) < 4) begin
      while (area.size() > target) void'(area.pop_back());
    end
  endfunction

  task automatic random_areas(int goal);
    logic [7:0] area[$];
    while (sb.walked_bytes < goal) begin
      build_area(area);
      send_area(area);
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    stall_request = 1'b0;
    quiet_cycles = 0;
    areas_sent = 0;
    src_idle_pct = 30;
    sink_idle_pct = 80;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one of each option type, timestamp with high bits set, EOL then a trailing byte
    send_area('{KIND_NOP, KIND_MSS, 8'd4, 8'h05, 8'hB4, KIND_WS, 8'd3, 8'h0E,
                KIND_SACKP, 8'd2, KIND_SACK, 8'd2, 8'h2A, 8'd2,
                KIND_TS, 8'd10, 8'h80, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFE,
                KIND_EOL, 8'h77});
    send_area('{KIND_SACK, 8'd0, 8'h55});
    send_area('{8'hFF, 8'd41});
    send_area('{KIND_MSS});
    send_area('{KIND_TS, 8'd40});
    send_area('{KIND_WS, 8'd1});

    random_areas(700);
    src_idle_pct = 80;
    sink_idle_pct = 30;
    random_areas(1400);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    stall_request = 1'b1;
    random_areas(2000);
    in_tvalid <= 1'b0;

    while (sb.expected_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d option bytes sent in %0d areas, %0d records checked",
             sb.walked_bytes, areas_sent, sb.checked);
    $display("tb: sender and receiver idling swapped, one %0d-cycle receiver hold",
             STALL_CYCLES);
    if (sb.errors == 0 && sb.expected_records.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0t: %0d mismatches, %0d records never arrived", $realtime, sb.errors,
               sb.expected_records.size());
      $display("tb: failure");
    end
    $finish;
  end
endmodule
